FILE: rtl/bts_pkg.sv
// Shared types and constants for the binary thinning sub-pass block.
// Depends on nothing; every module of the block imports it.
`timescale 1ns / 1ps

package bts_pkg;

  localparam int unsigned MaxWidth       = 64;  // row width in columns (1 to 64)
  localparam int unsigned RowW           = 64;  // width of a row field on the ports
  localparam int unsigned WidthW         = 7;   // width of the row_width register
  localparam int unsigned CfgIdxW        = 2;
  localparam int unsigned CfgDataW       = 7;
  localparam int unsigned SumW           = 4;
  localparam int unsigned NeighbourLimit = 7;
  localparam int unsigned FifoDepth      = 4;
  localparam int unsigned FifoPtrW       = $clog2(FifoDepth);
  localparam int unsigned FifoCntW       = $clog2(FifoDepth + 1);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ROW_WIDTH = 2'd0,
    CFG_SUB_PASS  = 2'd1
  } cfg_idx_e;

  // Rows held so far: saturates at two.
  typedef enum logic [1:0] {
    SEEN_NONE,
    SEEN_ONE,
    SEEN_TWO
  } rows_seen_e;

  typedef struct packed {
    logic [RowW-1:0] row_bits;
    logic            final_row;
  } in_beat_t;

  typedef struct packed {
    logic [RowW-1:0] out_row_bits;
    logic            out_final;
  } out_beat_t;

  // 3x3 window around one pixel; bit 0 is column c-1, bit 2 is column c+1.
  typedef struct packed {
    logic [2:0] up;
    logic [2:0] mid;
    logic [2:0] down;
  } window_t;

  // Pushes into the result queue; second implies first.
  typedef struct packed {
    logic first;
    logic second;
  } push_t;

  typedef struct packed {
    logic [FifoCntW-1:0] count;
    logic                pop;
  } fifo_status_t;

endpackage

FILE: rtl/binary_thinning_subpass.sv
// Zhang-Suen thinning sub-pass over a row stream: lanes, merge stage, result queue.
// A result beat is pushed into the result queue as the row that completes it is taken.
// Throughput: one row per cycle while the queue has room; the lanes take all columns
// of a row at once and the four-entry result queue absorbs a final row's two beats.
// Reset: width 64, first sub-pass, no rows held, queue empty.
// Depends on bts_pkg, bts_lane, bts_merge and bts_out_fifo.
`timescale 1ns / 1ps

module binary_thinning_subpass
  import bts_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // input rows
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_beat_t            in_data_i,
  // output rows
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_beat_t           out_data_o
);

  // ---------------------------------------------------------------------------
  // Config registers; user must write only while the block is idle (not enforced).
  // ---------------------------------------------------------------------------
  logic [WidthW-1:0] row_width_q;
  logic              sub_pass_q;
  logic              cfg_write;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q <= WidthW'(MaxWidth);
      sub_pass_q  <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index_i)
        CFG_ROW_WIDTH: row_width_q <= cfg_data_i[WidthW-1:0];
        CFG_SUB_PASS:  sub_pass_q  <= cfg_data_i[0];
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // Clamp the width: zero counts as one, anything above MaxWidth saturates.
  logic [WidthW-1:0] width_eff;

  always_comb begin
    if (row_width_q == '0) begin
      width_eff = WidthW'(1);
    end else if (row_width_q > WidthW'(MaxWidth)) begin
      width_eff = WidthW'(MaxWidth);
    end else begin
      width_eff = row_width_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Row history and handshake
  // ---------------------------------------------------------------------------
  rows_seen_e      state_q, state_d;
  logic [RowW-1:0] row_above_q, row_above_d;
  logic [RowW-1:0] row_middle_q, row_middle_d;
  logic            in_accept;
  fifo_status_t    fifo_status;

  // Take a row only while two free queue slots remain, the most that one row pushes.
  assign in_ready_o = fifo_status.count <= FifoCntW'(FifoDepth - 2);
  assign in_accept  = in_valid_i && in_ready_o;

  // ---------------------------------------------------------------------------
  // Lanes: one per interior column, fed from the unthinned rows.
  // The incoming row is the row below the middle one.
  // ---------------------------------------------------------------------------
  logic [RowW-1:0] lane_del;

  for (genvar c = 0; c < RowW; c++) begin : g_lane
    if (c >= 1 && c <= MaxWidth - 2) begin : g_core
      window_t win;
      assign win.up   = row_above_q[c+1:c-1];
      assign win.mid  = row_middle_q[c+1:c-1];
      assign win.down = in_data_i.row_bits[c+1:c-1];
      bts_lane u_lane (
        .win_i      (win),
        .sub_pass_i (sub_pass_q),
        .del_o      (lane_del[c])
      );
    end else begin : g_edge
      assign lane_del[c] = 1'b0;
    end
  end

  logic [RowW-1:0] thin_row;
  logic [RowW-1:0] col_mask;

  bts_merge u_merge (
    .mid_i   (row_middle_q),
    .del_i   (lane_del),
    .width_i (width_eff),
    .thin_o  (thin_row),
    .mask_o  (col_mask)
  );

  // ---------------------------------------------------------------------------
  // Row sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    if (in_accept) begin
      if (in_data_i.final_row) begin
        state_d = SEEN_NONE;  // flush done, ready for a new image
      end else begin
        unique case (state_q)
          SEEN_NONE: state_d = SEEN_ONE;
          SEEN_ONE:  state_d = SEEN_TWO;
          SEEN_TWO:  state_d = SEEN_TWO;
          default:   state_d = SEEN_NONE;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Row sequencer: outputs (queue pushes and history update)
  // ---------------------------------------------------------------------------
  push_t     push;
  out_beat_t first_beat;
  out_beat_t second_beat;

  always_comb begin
    push                     = '0;
    row_above_d              = row_above_q;
    row_middle_d             = row_middle_q;
    // the incoming row itself, used when it is flushed as the bottom border
    second_beat.out_row_bits = in_data_i.row_bits & col_mask;
    second_beat.out_final    = 1'b1;
    first_beat.out_row_bits  = row_middle_q & col_mask;
    first_beat.out_final     = 1'b0;
    if (in_accept) begin
      unique case (state_q)
        SEEN_NONE: begin
          if (in_data_i.final_row) begin
            // single-row image passes straight through
            push.first = 1'b1;
            first_beat = second_beat;
          end
        end
        SEEN_ONE: begin
          // top border row passes unchanged
          push.first  = 1'b1;
          push.second = in_data_i.final_row;
        end
        SEEN_TWO: begin
          push.first              = 1'b1;
          push.second             = in_data_i.final_row;
          first_beat.out_row_bits = thin_row;
        end
        default: ;
      endcase
      if (in_data_i.final_row) begin
        row_above_d  = '0;
        row_middle_d = '0;
      end else begin
        row_above_d  = row_middle_q;
        row_middle_d = in_data_i.row_bits;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= SEEN_NONE;
      row_above_q  <= '0;
      row_middle_q <= '0;
    end else begin
      state_q      <= state_d;
      row_above_q  <= row_above_d;
      row_middle_q <= row_middle_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result queue
  // ---------------------------------------------------------------------------
  bts_out_fifo u_out_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .first_i  (first_beat),
    .second_i (second_beat),
    .valid_o  (out_valid_o),
    .ready_i  (out_ready_i),
    .data_o   (out_data_o),
    .status_o (fifo_status)
  );

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_fifo_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_status.count <= FifoCntW'(FifoDepth))
    else $error("result queue overfilled");

  a_final_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && in_data_i.final_row) |=> (state_q == SEEN_NONE && row_middle_q == '0))
    else $error("final row did not return the history to empty");

  a_first_row_silent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && state_q == SEEN_NONE && !in_data_i.final_row) |=>
      (fifo_status.count == $past(fifo_status.count) - FifoCntW'($past(fifo_status.pop))))
    else $error("first row of an image produced a beat");

endmodule

FILE: rtl/bts_lane.sv
// One thinning lane: decides whether the centre pixel of a 3x3 window is removed.
// Depends on bts_pkg.
`timescale 1ns / 1ps

module bts_lane
  import bts_pkg::*;
(
  input  window_t win_i,
  input  logic    sub_pass_i,
  output logic    del_o
);

  logic [7:0]      ring;
  logic [SumW-1:0] sum;
  logic [SumW-1:0] trans;
  logic            keep_products;

  // ring order P2..P9
  assign ring = {win_i.up[0], win_i.mid[0], win_i.down[0], win_i.down[1],
                 win_i.down[2], win_i.mid[2], win_i.up[2], win_i.up[1]};

  always_comb begin
    sum   = '0;
    trans = '0;
    for (int k = 0; k < 8; k++) begin
      sum = sum + SumW'(ring[k]);
      if (!ring[k] && ring[(k + 1) % 8]) begin
        trans = trans + SumW'(1);
      end
    end
  end

  // ring[0]=P2, ring[2]=P4, ring[4]=P6, ring[6]=P8
  always_comb begin
    if (sub_pass_i) begin
      keep_products = !(ring[0] & ring[2] & ring[6]) && !(ring[0] & ring[4] & ring[6]);
    end else begin
      keep_products = !(ring[0] & ring[2] & ring[4]) && !(ring[2] & ring[4] & ring[6]);
    end
  end

  assign del_o = win_i.mid[1] && (sum > SumW'(1)) && (sum < SumW'(NeighbourLimit))
                 && (trans == SumW'(1)) && keep_products;

endmodule

FILE: rtl/bts_merge.sv
// Merge stage: combines the lane decisions with the column mask into the thinned row.
// Depends on bts_pkg.
`timescale 1ns / 1ps

module bts_merge
  import bts_pkg::*;
(
  input  logic [RowW-1:0]   mid_i,
  input  logic [RowW-1:0]   del_i,
  input  logic [WidthW-1:0] width_i,
  output logic [RowW-1:0]   thin_o,
  output logic [RowW-1:0]   mask_o
);

  logic [RowW-1:0] interior;

  always_comb begin
    for (int c = 0; c < RowW; c++) begin
      mask_o[c]   = WidthW'(c) < width_i;
      interior[c] = (c > 0) && (WidthW'(c + 1) < width_i);
    end
  end

  // border columns are never cleared; columns beyond the width are forced to zero
  assign thin_o = mid_i & mask_o & ~(del_i & interior);

endmodule

FILE: rtl/bts_out_fifo.sv
// Result queue: takes up to two beats per cycle and hands out one.
// Depends on bts_pkg.
`timescale 1ns / 1ps

module bts_out_fifo
  import bts_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  push_t        push_i,
  input  out_beat_t    first_i,
  input  out_beat_t    second_i,
  output logic         valid_o,
  input  logic         ready_i,
  output out_beat_t    data_o,
  output fifo_status_t status_o
);

  out_beat_t           mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wptr_q, wptr_d;
  logic [FifoPtrW-1:0] rptr_q, rptr_d;
  logic [FifoCntW-1:0] count_q, count_d;
  logic                pop;

  assign valid_o = count_q != '0;
  assign data_o  = mem_q[rptr_q];
  assign pop     = valid_o && ready_i;

  always_comb begin
    wptr_d  = wptr_q + FifoPtrW'(push_i.first) + FifoPtrW'(push_i.second);
    rptr_d  = rptr_q + FifoPtrW'(pop);
    count_d = count_q + FifoCntW'(push_i.first) + FifoCntW'(push_i.second)
              - FifoCntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.first) begin
      mem_q[wptr_q] <= first_i;
    end
    if (push_i.second) begin
      mem_q[wptr_q + FifoPtrW'(1)] <= second_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  assign status_o.count = count_q;
  assign status_o.pop   = pop;

endmodule

FILE: dv/thin_check_pkg.sv
// Scoreboard for the thinning sub-pass bench: a row-stream predictor and its queue of due rows.
// Depends on bts_pkg for the beat structs, the register indexes and the row-count states.
`timescale 1ns / 1ps

package thin_check_pkg;

  import bts_pkg::*;

  class thinning_scoreboard;

    logic [WidthW-1:0] row_width;
    logic              second_pass;
    logic [RowW-1:0]   row_above;
    logic [RowW-1:0]   row_middle;
    rows_seen_e        rows_held;
    out_beat_t         rows_due[$];
    int unsigned       rows_checked;
    int unsigned       errors;

    function new();
      row_width    = WidthW'(MaxWidth);
      second_pass  = 1'b0;
      rows_checked = 0;
      errors       = 0;
      forget_image();
    endfunction

    function void forget_image();
      row_above  = '0;
      row_middle = '0;
      rows_held  = SEEN_NONE;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_ROW_WIDTH: row_width = data[WidthW-1:0];
        CFG_SUB_PASS:  second_pass = data[0];
        default: ;
      endcase
    endfunction

    // Zero reads as one column; anything past MaxWidth saturates.
    function int unsigned used_width();
      int unsigned w;
      w = row_width;
      if (w == 0) w = 1;
      if (w > MaxWidth) w = MaxWidth;
      return w;
    endfunction

    function logic [RowW-1:0] used_mask();
      int unsigned w;
      w = used_width();
      if (w >= RowW) return '1;
      return (RowW'(1) << w) - 1'b1;
    endfunction

    // Thin the middle row against the unthinned rows either side of it.
    function logic [RowW-1:0] thin_row(logic [RowW-1:0] up, logic [RowW-1:0] mid,
                                       logic [RowW-1:0] down);
      int unsigned     w;
      logic [RowW-1:0] m;
      logic [RowW-1:0] kept;
      logic [7:0]      ring;
      int unsigned     rises;
      int unsigned     set_count;
      bit              products_ok;
      w    = used_width();
      m    = used_mask();
      up   = up & m;
      mid  = mid & m;
      down = down & m;
      kept = mid;
      for (int unsigned c = 1; c + 1 < w; c++) begin
        if (!mid[c]) continue;
        // ring[0] is north, then clockwise round to north-west in ring[7]
        ring = {up[c-1], mid[c-1], down[c-1], down[c], down[c+1], mid[c+1], up[c+1], up[c]};
        rises = 0;
        for (int k = 0; k < 8; k++) begin
          if (!ring[k] && ring[(k + 1) % 8]) rises++;
        end
        set_count = $countones(ring);
        if (second_pass) begin
          products_ok = !(ring[0] & ring[2] & ring[6]) && !(ring[0] & ring[4] & ring[6]);
        end else begin
          products_ok = !(ring[0] & ring[2] & ring[4]) && !(ring[2] & ring[4] & ring[6]);
        end
        if (set_count > 1 && set_count < NeighbourLimit && rises == 1 && products_ok) begin
          kept[c] = 1'b0;
        end
      end
      return kept & m;
    endfunction

    function void note_row(in_beat_t beat);
      logic [RowW-1:0] m;
      out_beat_t       due;
      m = used_mask();
      if (rows_held == SEEN_NONE) begin
        if (!beat.final_row) begin
          row_middle = beat.row_bits;
          rows_held  = SEEN_ONE;
          return;
        end
      end else begin
        // the first row of an image is a border row
        due.out_row_bits = (rows_held == SEEN_ONE) ? (row_middle & m)
                                                   : thin_row(row_above, row_middle,
                                                              beat.row_bits);
        due.out_final = 1'b0;
        rows_due.push_back(due);
        if (!beat.final_row) begin
          row_above  = row_middle;
          row_middle = beat.row_bits;
          rows_held  = SEEN_TWO;
          return;
        end
      end
      // final row: flush it unchanged and start a fresh image
      due.out_row_bits = beat.row_bits & m;
      due.out_final    = 1'b1;
      rows_due.push_back(due);
      forget_image();
    endfunction

    function int unsigned pending();
      return rows_due.size();
    endfunction

    task report(string what);
      errors++;
      $display("tb: error: %s", what);
    endtask

    task check_row(out_beat_t got);
      out_beat_t due;
      rows_checked++;
      if (rows_due.size() == 0) begin
        report($sformatf("row %0d unexpected: bits %h final %b", rows_checked,
                         got.out_row_bits, got.out_final));
        return;
      end
      due = rows_due.pop_front();
      if (got.out_row_bits !== due.out_row_bits) begin
        report($sformatf("row %0d bits: got %h want %h", rows_checked,
                         got.out_row_bits, due.out_row_bits));
      end
      if (got.out_final !== due.out_final) begin
        report($sformatf("row %0d final flag: got %b want %b", rows_checked,
                         got.out_final, due.out_final));
      end
    endtask

    task close();
      if (rows_due.size() != 0) begin
        report($sformatf("%0d rows never arrived", rows_due.size()));
      end
    endtask

  endclass

endpackage

FILE: dv/tb.sv
// Bench top for binary_thinning_subpass: drives row images and register writes, checks rows.
// Depends on bts_pkg, thin_check_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb;

  import bts_pkg::*;
  import thin_check_pkg::*;

  localparam int unsigned ResetCycles    = 9;
  localparam int unsigned SettleCycles   = 6;     // a row's beat is queued as the row is taken
  localparam int unsigned HoldCycles     = 300;   // long receiver hold-off, fills the queue
  localparam int unsigned WatchdogCycles = 4000;  // well above the hold-off and any gap
  localparam int unsigned ItemsTarget    = 1250;
  localparam int unsigned PhaseItems     = 100;

  typedef enum int {
    IMG_NOISE,
    IMG_DENSE,
    IMG_SPARSE,
    IMG_SOLID,
    IMG_BLOB
  } image_style_e;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = CFG_ROW_WIDTH;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  in_beat_t            in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_beat_t           out_data;

  thinning_scoreboard board = new();

  int unsigned in_idle_max  = 0;
  int unsigned out_idle_max = 0;
  bit          hold_results = 1'b0;
  int unsigned rows_sent    = 0;
  int unsigned quiet_cycles = 0;

  always #2 clk = ~clk;

  binary_thinning_subpass dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  // ---------------------------------------------------------------------------
  // Watchdog: count cycles with no beat on any channel; give up at the limit.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WatchdogCycles) begin
        $display("tb: no beat for %0d cycles", WatchdogCycles);
        $display("tb: FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: draw a stall per beat, honour a requested long hold-off, and hand
  // every accepted beat to the scoreboard. Drive at the falling edge, sample at
  // the rising one.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned gap;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (hold_results) begin
        // hold ready low while the sender keeps pushing, so the block backs up
        out_ready = 1'b0;
        repeat (HoldCycles) @(negedge clk);
        hold_results = 1'b0;
      end
      gap = $urandom_range(0, out_idle_max);
      if (gap > 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      board.check_row(out_data);
      @(negedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side. Every task starts and ends at a falling edge. Valid stays high
  // from one row to the next when no gap is drawn; it is dropped explicitly
  // before any pause.
  // ---------------------------------------------------------------------------
  task automatic send_row(input logic [RowW-1:0] bits, input logic last);
    int unsigned gap;
    gap = $urandom_range(0, in_idle_max);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data.row_bits  = bits;
    in_data.final_row = last;
    in_valid          = 1'b1;
    do @(posedge clk); while (!in_ready);
    board.note_row(in_data);
    rows_sent++;
    @(negedge clk);
  endtask

  // Stop offering rows and wait until every due row has come back.
  task automatic drain_results();
    in_valid = 1'b0;
    while (board.pending() != 0) @(negedge clk);
  endtask

  task automatic set_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_index = idx;
    cfg_data  = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(cfg_idx_e'(idx), data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Registers change only with the block idle: drain, then let a held first
  // row (which owes no result yet) settle inside the block.
  task automatic configure(input logic [CfgDataW-1:0] width, input logic [CfgDataW-1:0] pass);
    drain_results();
    repeat (SettleCycles) @(negedge clk);
    set_reg(CFG_ROW_WIDTH, width);
    set_reg(CFG_SUB_PASS, pass);
  endtask

  function automatic logic [RowW-1:0] random_row();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [RowW-1:0] run_bits(input int lo, input int len);
    logic [RowW-1:0] run;
    run = (len >= RowW) ? '1 : ((RowW'(1) << len) - 1'b1);
    return run << lo;
  endfunction

  // One whole image; blobs wander a little from row to row so that thick
  // strokes with real edges reach the thinning rules.
  task automatic send_image(input int unsigned height);
    image_style_e    style;
    int unsigned     pick;
    int              lo;
    int              len;
    logic [RowW-1:0] bits;
    pick  = $urandom_range(0, 7);
    style = (pick > IMG_BLOB) ? IMG_BLOB : image_style_e'(pick);
    lo    = $urandom_range(0, 20);
    len   = $urandom_range(3, 30);
    for (int unsigned r = 0; r < height; r++) begin
      case (style)
        IMG_NOISE:  bits = random_row();
        IMG_DENSE:  bits = random_row() | random_row();
        IMG_SPARSE: bits = random_row() & random_row();
        IMG_SOLID:  bits = ~(random_row() & random_row() & random_row());
        default: begin
          lo  = lo + int'($urandom_range(0, 4)) - 2;
          len = len + int'($urandom_range(0, 6)) - 3;
          if (lo < 0) lo = 0;
          if (lo > RowW - 2) lo = RowW - 2;
          if (len < 1) len = 1;
          if (len > RowW) len = RowW;
          bits = run_bits(lo, len);
          if ($urandom_range(0, 3) == 0) bits ^= random_row() & random_row() & random_row();
        end
      endcase
      send_row(bits, r + 1 == height);
    end
  endtask

  function automatic int unsigned pick_height();
    case ($urandom_range(0, 15))
      0:       return 1;
      1:       return 2;
      2:       return $urandom_range(20, 40);
      default: return $urandom_range(3, 10);
    endcase
  endfunction

  // Widths lean towards the edges of the range, past the lanes included.
  function automatic logic [CfgDataW-1:0] pick_width();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return CfgDataW'(1);
      2:       return CfgDataW'(2);
      3:       return CfgDataW'(3);
      4:       return CfgDataW'(MaxWidth);
      5:       return CfgDataW'($urandom_range(MaxWidth + 1, 2 ** WidthW - 1));
      default: return CfgDataW'($urandom_range(4, MaxWidth - 1));
    endcase
  endfunction

  function automatic int unsigned pick_idle();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 16;
      default: return $urandom_range(1, 16);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed images, then random phases.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned phase;
    int unsigned phase_start;
    int unsigned burst;
    repeat (ResetCycles) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed part, reset settings first: full width, first sub-pass.
    in_idle_max  = 2;
    out_idle_max = 2;
    send_row('1, 1'b1);                           // single-row image leaves at once
    send_row('1, 1'b0);                           // solid image: eight neighbours, all kept
    send_row('1, 1'b0);
    send_row('1, 1'b1);
    send_row(RowW'(0), 1'b0);                     // 3x3 blob: corners and the east and south edges go
    send_row(RowW'('h0e), 1'b0);
    send_row(RowW'('h0e), 1'b0);
    send_row(RowW'('h0e), 1'b0);
    send_row(RowW'(0), 1'b1);
    send_row(random_row(), 1'b0);                 // two-row image: both borders
    send_row(random_row(), 1'b1);

    configure('0, CfgDataW'(1));                  // zero width reads as one column
    send_row('1, 1'b0);
    send_row('1, 1'b0);
    send_row('1, 1'b1);
    configure(CfgDataW'(2), '1);                  // two columns: no interior
    send_row('1, 1'b0);
    send_row('1, 1'b0);
    send_row('1, 1'b1);
    configure(CfgDataW'(3), CfgDataW'(1));        // narrowest image with an interior column
    send_row(RowW'('b110), 1'b0);
    send_row(RowW'('b111), 1'b0);
    send_row(RowW'('b011), 1'b0);
    send_row(RowW'('b111), 1'b1);
    configure('1, '0);                            // oversize width saturates
    set_reg(CfgIdxW'($urandom_range(CFG_SUB_PASS + 1, 2 ** CfgIdxW - 1)), CfgDataW'($urandom));
    send_row(random_row(), 1'b0);
    send_row(random_row(), 1'b1);

    // Random phases of roughly PhaseItems rows each.
    phase = 0;
    while (rows_sent < ItemsTarget) begin
      phase++;
      configure(pick_width(), CfgDataW'($urandom));
      if ($urandom_range(0, 3) == 0) begin
        set_reg(CfgIdxW'($urandom_range(CFG_SUB_PASS + 1, 2 ** CfgIdxW - 1)),
                CfgDataW'($urandom));
      end
      in_idle_max  = pick_idle();
      out_idle_max = pick_idle();
      if (phase == 3) begin
        // back-to-back rows against a long hold-off on the result side
        in_idle_max  = 0;
        hold_results = 1'b1;
      end
      phase_start = rows_sent;
      while (rows_sent - phase_start < PhaseItems && rows_sent < ItemsTarget) begin
        if ($urandom_range(0, 9) == 0) begin
          // loose rows with a random final flag; may leave an image open
          // across a register change
          burst = $urandom_range(1, 6);
          repeat (burst) send_row(random_row(), $urandom_range(0, 3) == 0);
        end else begin
          send_image(pick_height());
        end
        if (phase == 5 && rows_sent - phase_start > PhaseItems / 2) begin
          // pause mid-phase until every due row is back, then carry on
          drain_results();
          phase++;
        end
      end
    end

    drain_results();
    repeat (SettleCycles) @(negedge clk);
    board.close();
    if (board.errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
